// ===== sv/sfn_pkg.sv =====
// ----------------------------------------------------------------------------
// sfn_pkg
// Shared types, constants and byte checks for the short file name formatter.
// ----------------------------------------------------------------------------
package sfn_pkg;

  localparam int NameLen = 11;
  localparam int BaseLen = 8;
  localparam int IdxW    = 4;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NameLen - 1);

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChDeleted = 8'hE5;
  localparam logic [7:0] ChKanjiLead = 8'h05;

  // check modes
  localparam logic [1:0] ModeRelaxed = 2'd0;
  localparam logic [1:0] ModeNormal  = 2'd1;
  localparam logic [1:0] ModeStrict  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] RegCheckMode = 2'd0;
  localparam logic [1:0] RegAllowDot  = 2'd1;
  localparam logic [1:0] RegKeepCase  = 2'd2;

  typedef enum logic [2:0] {
    PH_START,
    PH_BASE,
    PH_SKIP,
    PH_EXT,
    PH_EXTFULL,
    PH_DONE
  } sfn_phase_t;

  typedef struct packed {
    logic [1:0] check_mode;
    logic       allow_dot;
    logic       keep_case;
  } sfn_cfg_t;

  typedef struct packed {
    logic                      err;
    logic                      hidden;
    logic [NameLen-1:0][7:0]   bytes;
  } sfn_result_t;

  function automatic logic char_bad(input logic [7:0] c, input logic [1:0] mode);
    logic bad;
    bad = (c < 8'h20) || (c == 8'h3A) || (c == 8'h5C);
    if (mode != ModeRelaxed &&
        (c == 8'h2A || c == 8'h3F || c == 8'h3C || c == 8'h3E || c == 8'h7C ||
         c == 8'h22))
      bad = 1'b1;
    if (mode == ModeStrict &&
        (c == 8'h2B || c == 8'h3D || c == 8'h2C || c == 8'h3B || c == ChSpace ||
         (c >= 8'h41 && c <= 8'h5A)))
      bad = 1'b1;
    return bad;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c, input logic keep_case);
    logic [7:0] r;
    r = c;
    if (!keep_case && c >= 8'h61 && c <= 8'h7A)
      r = c - 8'd32;
    return r;
  endfunction

endpackage

// ===== sv/short_file_name_formatter.sv =====
// ----------------------------------------------------------------------------
// short_file_name_formatter
// Streams a file name in byte by byte and returns its 11-byte 8.3 short name.
// ----------------------------------------------------------------------------
// Name bytes are taken one per cycle while in_tready is high. On the beat
// marked tlast the finished name is loaded into an output buffer, which then
// sends 11 beats (index 0..10, the last with tlast) or one error beat (status
// 1, byte and index 0). While the buffer holds a name, in_tready is low except
// in the cycle its final beat leaves, so bytes of the next name are held back
// while the output buffer drains the last name byte by byte. Configuration
// writes are taken every cycle and apply from the next name byte.
module short_file_name_formatter import sfn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] name_char
  input  logic        in_tlast,   // is_final
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [11:8] byte_index, zero fill
  output logic [1:0]  out_tuser,  // [0] status, [1] hidden
  output logic        out_tlast,  // run_end
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data
);

  sfn_cfg_t    cfg_r;
  sfn_result_t result;
  logic        in_acc;
  logic        out_acc;

  logic                    ob_valid_r;
  logic [NameLen-1:0][7:0] ob_bytes_r;
  logic [IdxW-1:0]         ob_idx_r;
  logic                    ob_err_r;
  logic                    ob_hid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_mode <= ModeNormal;
      cfg_r.allow_dot  <= 1'b0;
      cfg_r.keep_case  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegCheckMode: cfg_r.check_mode <= cfg_data;
        RegAllowDot:  cfg_r.allow_dot  <= cfg_data[0];
        RegKeepCase:  cfg_r.keep_case  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_tvalid = ob_valid_r;
  assign out_tlast  = ob_err_r || (ob_idx_r == LastIdx);
  assign out_tdata  = {4'b0, ob_idx_r, ob_bytes_r[0]};
  assign out_tuser  = {ob_hid_r, ob_err_r};
  assign out_acc    = out_tvalid && out_tready;
  assign in_tready  = !ob_valid_r || (out_tready && out_tlast);
  assign in_acc     = in_tvalid && in_tready;

  sfn_name_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (in_acc),
    .name_char (in_tdata),
    .is_final  (in_tlast),
    .result    (result)
  );

  // output buffer, shifts one byte down per beat
  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      ob_bytes_r <= result.bytes;
      ob_err_r   <= result.err;
      ob_hid_r   <= result.hidden;
    end else if (out_acc) begin
      ob_bytes_r <= {8'h00, ob_bytes_r[NameLen-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_valid_r <= 1'b0;
      ob_idx_r   <= '0;
    end else if (in_acc && in_tlast) begin
      ob_valid_r <= 1'b1;
      ob_idx_r   <= '0;
    end else if (out_acc) begin
      if (out_tlast) begin
        ob_valid_r <= 1'b0;
        ob_idx_r   <= '0;
      end else begin
        ob_idx_r <= ob_idx_r + 1'b1;
      end
    end
  end

endmodule

// ===== sv/sfn_name_core.sv =====
// ----------------------------------------------------------------------------
// sfn_name_core
// Name parser: checks each byte and places it in the 8.3 name buffer.
// ----------------------------------------------------------------------------
module sfn_name_core import sfn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  sfn_cfg_t    cfg,
  input  logic        accept,
  input  logic [7:0]  name_char,
  input  logic        is_final,
  output sfn_result_t result
);

  logic [7:0]  sn_r   [NameLen];
  logic [7:0]  sn_nxt [NameLen];
  logic [IdxW-1:0] fill_r, fill_nxt;
  sfn_phase_t  phase_r, phase_nxt;
  logic        rej_r, rej_nxt;
  logic        ts_r, ts_nxt;
  logic        hid_r, hid_nxt;
  logic [7:0]  cm;
  logic        strict;
  logic        base_step;

  assign strict = (cfg.check_mode == ModeStrict);

  always_comb begin
    sn_nxt    = sn_r;
    fill_nxt  = fill_r;
    phase_nxt = phase_r;
    rej_nxt   = rej_r;
    ts_nxt    = ts_r;
    hid_nxt   = hid_r;
    base_step = 1'b0;
    cm        = ((fill_r == '0) && (name_char == ChDeleted)) ? ChKanjiLead : name_char;

    if (!rej_r) begin
      unique case (phase_r)
        PH_START: begin
          if (name_char == ChDot) begin
            if (cfg.allow_dot) begin
              hid_nxt   = 1'b1;
              phase_nxt = PH_BASE;
            end else begin
              rej_nxt = 1'b1;
            end
          end else begin
            phase_nxt = PH_BASE;
            base_step = 1'b1;
          end
        end
        PH_BASE: base_step = 1'b1;
        PH_SKIP: begin
          if (name_char == ChDot) begin
            for (int j = 0; j < BaseLen; j++)
              if (IdxW'(j) >= fill_r) sn_nxt[j] = ChSpace;
            fill_nxt  = IdxW'(BaseLen);
            ts_nxt    = 1'b0;
            phase_nxt = PH_EXT;
          end else if (strict) begin
            rej_nxt = 1'b1;
          end
        end
        PH_EXT: begin
          if (char_bad(name_char, cfg.check_mode)) begin
            rej_nxt = 1'b1;
          end else if (name_char == ChDot) begin
            if (strict) rej_nxt = 1'b1;
            else        phase_nxt = PH_DONE;
          end else begin
            ts_nxt = (name_char == ChSpace);
            if (fill_r < IdxW'(NameLen)) begin
              sn_nxt[fill_r] = fold(name_char, cfg.keep_case);
              fill_nxt       = fill_r + 1'b1;
            end
            if (fill_nxt >= IdxW'(NameLen)) phase_nxt = PH_EXTFULL;
          end
        end
        PH_EXTFULL: if (strict) rej_nxt = 1'b1;
        PH_DONE: ;
        default: ;
      endcase

      if (base_step) begin
        if (char_bad(name_char, cfg.check_mode)) begin
          rej_nxt = 1'b1;
        end else if (cm == ChDot) begin
          if (ts_r) begin
            rej_nxt = 1'b1;
          end else begin
            for (int j = 0; j < BaseLen; j++)
              if (IdxW'(j) >= fill_r) sn_nxt[j] = ChSpace;
            fill_nxt  = IdxW'(BaseLen);
            ts_nxt    = 1'b0;
            phase_nxt = PH_EXT;
          end
        end else begin
          ts_nxt = (cm == ChSpace);
          if (fill_r < IdxW'(BaseLen)) begin
            sn_nxt[fill_r] = fold(cm, cfg.keep_case);
            fill_nxt       = fill_r + 1'b1;
          end
          if (fill_nxt >= IdxW'(BaseLen)) begin
            if (ts_nxt) rej_nxt = 1'b1;
            else        phase_nxt = PH_SKIP;
          end
        end
      end
    end
  end

  // padded snapshot of the finished name
  always_comb begin
    result.err    = rej_nxt | ts_nxt;
    result.hidden = hid_nxt & ~result.err;
    for (int j = 0; j < NameLen; j++) begin
      if (result.err)                 result.bytes[j] = '0;
      else if (IdxW'(j) < fill_nxt)   result.bytes[j] = sn_nxt[j];
      else                            result.bytes[j] = ChSpace;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) sn_r <= sn_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      phase_r <= PH_START;
      rej_r   <= 1'b0;
      ts_r    <= 1'b1;
      hid_r   <= 1'b0;
    end else if (accept) begin
      if (is_final) begin
        fill_r  <= '0;
        phase_r <= PH_START;
        rej_r   <= 1'b0;
        ts_r    <= 1'b1;
        hid_r   <= 1'b0;
      end else begin
        fill_r  <= fill_nxt;
        phase_r <= phase_nxt;
        rej_r   <= rej_nxt;
        ts_r    <= ts_nxt;
        hid_r   <= hid_nxt;
      end
    end
  end

endmodule

// ===== sv/sfn_checker.sv =====
// ----------------------------------------------------------------------------
// sfn_checker
// Port-level checks for the short file name formatter, bound to the top level.
// ----------------------------------------------------------------------------
module sfn_checker import sfn_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // index steps by one within a run
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && out_tdata[11:8] == IdxW'($past(out_tdata[11:8]) + 1'b1)))
    else $error("byte index did not advance by one");

  // error beat is a lone, empty beat
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      (out_tlast && out_tdata[11:0] == 12'h000 && !out_tuser[1]))
    else $error("error beat carries data or is not last");

  // a good run ends exactly at the last index
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tlast == (out_tdata[11:8] == LastIdx)))
    else $error("run end does not match index 10");

  // input only held back while a run is being sent
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no output pending");

endmodule

bind short_file_name_formatter sfn_checker u_sfn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
